// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define B64E_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("b64e check failed");

// Clocked check, also evaluated during reset.
`define B64E_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("b64e check failed");

`endif

// ===== rtl/core/b64e_pkg.sv =====
`default_nettype none

package b64e_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } t_out;

    typedef enum logic [1:0] {
        PH0 = 2'd0,
        PH1 = 2'd1,
        PH2 = 2'd2
    } t_phase;

    // One queued job: up to four characters, count minus one, end-of-message flag.
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      cnt_m1;
        logic            fin;
    } t_job;

    localparam logic [6:0] CH_PAD   = 7'h3D;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_SLASH = 7'h2F;

    function automatic logic [6:0] b64_char(input logic [5:0] s);
        logic [6:0] c;
        if (s < 6'd26) begin
            c = 7'(s) + 7'h41;
        end else if (s < 6'd52) begin
            c = 7'(s) + 7'h47;
        end else if (s < 6'd62) begin
            c = 7'(s) - 7'd4;
        end else if (s == 6'd62) begin
            c = CH_PLUS;
        end else begin
            c = CH_SLASH;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b64e_front.sv =====
`default_nettype none

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_job      o_job
);

    t_phase     r_phase, n_phase;
    logic [5:0] r_carry, n_carry;
    logic [7:0] b;
    logic       fin;

    assign b          = i_in_data.data_byte;
    assign fin        = i_in_data.last_byte;
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        n_phase = r_phase;
        n_carry = r_carry;
        unique case (r_phase)
            PH1: begin
                n_phase = fin ? PH0 : PH2;
                n_carry = fin ? 6'd0 : {b[3:0], 2'b00};
            end
            PH2: begin
                n_phase = PH0;
                n_carry = 6'd0;
            end
            default: begin
                n_phase = fin ? PH0 : PH1;
                n_carry = fin ? 6'd0 : {b[1:0], 4'b0000};
            end
        endcase
    end

    always_comb begin
        o_job.chars  = {4{CH_PAD}};
        o_job.cnt_m1 = 2'd0;
        o_job.fin    = fin;
        unique case (r_phase)
            PH1: begin
                o_job.chars[0] = b64_char(r_carry | {2'b00, b[7:4]});
                o_job.chars[1] = b64_char({b[3:0], 2'b00});
                o_job.cnt_m1   = fin ? 2'd2 : 2'd0;
            end
            PH2: begin
                o_job.chars[0] = b64_char(r_carry | {4'b0000, b[7:6]});
                o_job.chars[1] = b64_char(b[5:0]);
                o_job.cnt_m1   = 2'd1;
            end
            default: begin
                o_job.chars[0] = b64_char(b[7:2]);
                o_job.chars[1] = b64_char({b[1:0], 4'b0000});
                o_job.cnt_m1   = fin ? 2'd3 : 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH0;
            r_carry <= 6'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/b64e_queue.sv =====
`default_nettype none

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int QDEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_head_valid,
    output t_job      o_head,
    input  wire logic i_pop
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full       = (r_cnt == CW'(QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/b64e_back.sv =====
`default_nettype none

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_head_valid,
    input  wire t_job i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out       r_out;
    logic       load, at_end;

    assign load        = !r_out_valid || i_out_ready;
    assign at_end      = (r_idx == i_head.cnt_m1);
    assign o_pop       = load && i_head_valid && at_end;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_out.out_char  <= i_head.chars[r_idx];
            r_out.last_char <= i_head.fin && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_head_valid;
            if (i_head_valid) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/base64_stream_encoder.sv =====
// Channel   Dir  Handshake                 Payload
// in        in   i_in_valid / o_in_ready   i_in_data  (t_in: data_byte, last_byte)
// out       out  o_out_valid / i_out_ready o_out_data (t_out: out_char, last_char)
//
// One character leaves per cycle while i_out_ready is high and a job is queued; the output register sets that pace.
// A byte yields 1 or 2 characters, up to 4 on a last byte.
// The first character of a byte passes through the queue write, then the output register load, before it is valid.
// Input stalls only when the QDEPTH-entry job queue is full.
// Synchronous active-low reset clears phase, carry, queue and output valid.
`default_nettype none

module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int QDEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic q_full, push, head_valid, pop;
    t_job job, head;

    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job)
    );

    b64e_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/b64e_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module b64e_checker
    import b64e_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire t_in  i_in_data,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire t_out i_out_data
);

    logic [6:0] c;
    logic       legal;

    assign c     = i_out_data.out_char;
    assign legal = (c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A) ||
                   (c >= 7'h30 && c <= 7'h39) || (c == CH_PLUS) ||
                   (c == CH_SLASH) || (c == CH_PAD);

    `B64E_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !i_out_valid)
    `B64E_ASSERT(a_in_hold, i_in_valid && !i_in_ready |=> i_in_valid && $stable(i_in_data))
    `B64E_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
    `B64E_ASSERT(a_char_legal, i_out_valid |-> legal)
    `B64E_ASSERT(a_no_out_from_nothing,
        $past(i_rst_n) && !$past(i_in_valid) && !$past(i_out_valid) &&
        !$past(i_out_valid, 2) && !$past(i_in_valid, 2) |-> !i_out_valid)

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire
